// File: sv/tas_pkg.sv
// Shared types, constants and lookup functions of the trajectory action sampler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package tas_pkg;

  localparam int unsigned ACTION_DEPTH = 1024;
  localparam int unsigned SLOT_W       = $clog2(ACTION_DEPTH);
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned CORDIC_STEPS = 18;
  localparam int unsigned DIV_STEPS    = 64;
  localparam int unsigned MUL_STEPS    = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam logic signed [30:0] CORDIC_GAIN = 31'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_TIME   = 2'd0,
    CFG_STEP_MS      = 2'd1,
    CFG_ACTION_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_SCHED   = 3'd0,
    ST_STOP    = 3'd1,
    ST_ACTIVE  = 3'd2,
    ST_GRACE   = 3'd3,
    ST_EXPIRED = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [15:0] spin_accel;
    logic signed [15:0] field_acc_y;
    logic signed [15:0] field_acc_x;
    logic signed [15:0] spin_rate;
    logic signed [15:0] field_vel_y;
    logic signed [15:0] field_vel_x;
  } action_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOT_W-1:0]  slot_used;
    logic [16:0]        progress;
    logic signed [15:0] body_vel_x;
    logic signed [15:0] body_vel_y;
    logic signed [15:0] body_acc_x;
    logic signed [15:0] body_acc_y;
    logic signed [15:0] spin_target;
    logic signed [15:0] spin_accel_target;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic query;
    logic setup;
    logic div_step;
    logic check;
    logic rot_init;
    logic rot_step;
    logic mul_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sched;
    logic stop;
    logic div_done;
    logic expired;
    logic prog_skip;
    logic rot_done;
    logic mul_done;
    logic out_free;
  } sts_t;

  // Grace span in slots: 20 ms divided by the slot length, at least one slot.
  function automatic logic [4:0] grace_of(input logic [15:0] step);
    logic [4:0] g;
    case (step)
      16'd1:   g = 5'd20;
      16'd2:   g = 5'd10;
      16'd3:   g = 5'd6;
      16'd4:   g = 5'd5;
      16'd5:   g = 5'd4;
      16'd6:   g = 5'd3;
      16'd7, 16'd8, 16'd9, 16'd10: g = 5'd2;
      default: g = 5'd1;
    endcase
    return g;
  endfunction

  // Arc tangent of 2^-i in units of 2^32 per turn.
  function automatic logic signed [32:0] atan_of(input logic [4:0] i);
    logic signed [32:0] a;
    case (i)
      5'd0:    a = 33'sd536870912;
      5'd1:    a = 33'sd316933406;
      5'd2:    a = 33'sd167458907;
      5'd3:    a = 33'sd85004756;
      5'd4:    a = 33'sd42667331;
      5'd5:    a = 33'sd21354465;
      5'd6:    a = 33'sd10679838;
      5'd7:    a = 33'sd5340245;
      5'd8:    a = 33'sd2670163;
      5'd9:    a = 33'sd1335087;
      5'd10:   a = 33'sd667544;
      5'd11:   a = 33'sd333772;
      5'd12:   a = 33'sd166886;
      5'd13:   a = 33'sd83443;
      5'd14:   a = 33'sd41722;
      5'd15:   a = 33'sd20861;
      5'd16:   a = 33'sd10430;
      5'd17:   a = 33'sd5215;
      default: a = 33'sd0;
    endcase
    return a;
  endfunction

endpackage

// File: sv/tas_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on tas_pkg for the slot width.
`timescale 1ns / 1ps
interface tas_in_if;
  import tas_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SLOT_W-1:0]   action_slot;
  logic signed [15:0]  field_vel_x;
  logic signed [15:0]  field_vel_y;
  logic signed [15:0]  spin_rate;
  logic signed [15:0]  field_acc_x;
  logic signed [15:0]  field_acc_y;
  logic signed [15:0]  spin_accel;
  logic [63:0]         query_time_us;
  logic signed [15:0]  heading;
  modport source (output valid, mode, action_slot, field_vel_x, field_vel_y, spin_rate,
                  field_acc_x, field_acc_y, spin_accel, query_time_us, heading,
                  input ready);
  modport sink (input valid, mode, action_slot, field_vel_x, field_vel_y, spin_rate,
                field_acc_x, field_acc_y, spin_accel, query_time_us, heading,
                output ready);
endinterface

interface tas_out_if;
  import tas_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [SLOT_W-1:0]   slot_used;
  logic [16:0]         progress;
  logic signed [15:0]  body_vel_x;
  logic signed [15:0]  body_vel_y;
  logic signed [15:0]  body_acc_x;
  logic signed [15:0]  body_acc_y;
  logic signed [15:0]  spin_target;
  logic signed [15:0]  spin_accel_target;
  modport source (output valid, status, slot_used, progress, body_vel_x, body_vel_y,
                  body_acc_x, body_acc_y, spin_target, spin_accel_target,
                  input ready);
  modport sink (input valid, status, slot_used, progress, body_vel_x, body_vel_y,
                body_acc_x, body_acc_y, spin_target, spin_accel_target,
                output ready);
endinterface

// File: sv/tas_ctrl.sv
// Controller state machine of the trajectory action sampler.
// Depends on tas_pkg for the command and status structs.
`timescale 1ns / 1ps
module tas_ctrl
  import tas_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_mode_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SETUP = 9'b000000010,
    S_DIV1  = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_DIV2  = 9'b000010000,
    S_RINIT = 9'b000100000,
    S_ROT   = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i) begin
            cmd_o.query = 1'b1;
            state_d = S_SETUP;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = (sts_i.sched || sts_i.stop) ? S_FIN : S_DIV1;
      end
      S_DIV1: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.expired) state_d = S_FIN;
        else if (sts_i.prog_skip) state_d = S_RINIT;
        else state_d = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_RINIT;
      end
      S_RINIT: begin
        cmd_o.rot_init = 1'b1;
        state_d = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot_step = 1'b1;
        if (sts_i.rot_done) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/tas_dp.sv
// Datapath: configuration, action memory, shared serial divider, CORDIC and gain stage.
// Depends on tas_pkg; driven by commands from tas_ctrl.
`timescale 1ns / 1ps
module tas_dp
  import tas_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  action_t              action_i,
  input  logic [63:0]          time_i,
  input  logic signed [15:0]   heading_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output result_t              result_o
);

  logic [63:0]        start_q;
  logic [15:0]        step_q;
  logic [COUNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      step_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_TIME:   start_q <= cfg_data_i;
        CFG_STEP_MS:      step_q  <= cfg_data_i[15:0];
        CFG_ACTION_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COUNT_W-1:0] n, nm1;
  assign n   = (count_q > COUNT_W'(ACTION_DEPTH)) ? COUNT_W'(ACTION_DEPTH) : count_q;
  assign nm1 = n - COUNT_W'(1);

  // Query operands.
  logic [63:0]        time_q;
  logic signed [15:0] heading_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      time_q    <= time_i;
      heading_q <= heading_i;
    end
  end

  // Action memory with registered read.
  logic [95:0]       mem [ACTION_DEPTH];
  action_t           rd_q;
  logic [SLOT_W-1:0] sel;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem[slot_i] <= action_i;
    if (cmd_i.check) rd_q <= mem[sel];
  end

  // Restoring divider, one quotient bit a cycle.
  logic [63:0] quo_q, quo_d;
  logic [26:0] rem_q, rem_d, trial;
  logic [25:0] dvs_q, dvs_d;
  logic [5:0]  div_cnt_q;
  logic        ge;
  logic [27:0] prog_num;

  assign trial    = {rem_q[25:0], quo_q[63]};
  assign ge       = trial >= {1'b0, dvs_q};
  assign prog_num = {1'b0, sel, 17'd0} + 28'(nm1);

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (cmd_i.setup) begin
      quo_d = time_q - start_q;
      rem_d = '0;
      dvs_d = 26'(step_q) * 26'd1000;
    end else if (cmd_i.check) begin
      quo_d = 64'(prog_num);
      rem_d = '0;
      dvs_d = 26'({nm1, 1'b0});
    end else if (cmd_i.div_step) begin
      rem_d = ge ? trial - {1'b0, dvs_q} : trial;
      quo_d = {quo_q[62:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.setup || cmd_i.check) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 6'd1;
    end
  end

  // Timing decisions.
  logic       active, expired;
  logic [4:0] grace;
  status_e    stat_q;
  logic       prog_one_q;

  assign grace   = grace_of(step_q);
  assign active  = quo_q < 64'(n);
  assign expired = quo_q >= (64'(n) + 64'(grace));
  assign sel     = active ? quo_q[SLOT_W-1:0] : SLOT_W'(nm1);

  logic [SLOT_W-1:0] sel_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      stat_q     <= (time_q < start_q) ? ST_SCHED : ST_STOP;
      prog_one_q <= 1'b1;
    end else if (cmd_i.check) begin
      stat_q     <= expired ? ST_EXPIRED : (active ? ST_ACTIVE : ST_GRACE);
      sel_q      <= sel;
      prog_one_q <= n <= COUNT_W'(1);
    end
  end

  // Two-lane CORDIC sharing one angle register.
  localparam logic signed [32:0] ZLIM = 33'sd1073741824;
  localparam logic signed [32:0] ZHALF = 33'sd2147483648;
  logic signed [32:0] x0_q, y0_q, x1_q, y1_q, z_q;
  logic signed [32:0] ix0, iy0, ix1, iy1, iz;
  logic [4:0]         rot_cnt_q;
  logic               zpos;

  always_comb begin
    ix0 = 33'(rd_q.field_vel_x) <<< 14;
    iy0 = 33'(rd_q.field_vel_y) <<< 14;
    ix1 = 33'(rd_q.field_acc_x) <<< 14;
    iy1 = 33'(rd_q.field_acc_y) <<< 14;
    iz  = $signed({heading_q[15], heading_q, 16'h0000});
    if (iz > ZLIM) begin
      ix0 = -ix0; iy0 = -iy0; ix1 = -ix1; iy1 = -iy1;
      iz  = iz - ZHALF;
    end else if (iz < -ZLIM) begin
      ix0 = -ix0; iy0 = -iy0; ix1 = -ix1; iy1 = -iy1;
      iz  = iz + ZHALF;
    end
  end

  assign zpos = !z_q[32];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rot_init) begin
      x0_q <= ix0; y0_q <= iy0; x1_q <= ix1; y1_q <= iy1; z_q <= iz;
    end else if (cmd_i.rot_step) begin
      if (zpos) begin
        x0_q <= x0_q - (y0_q >>> rot_cnt_q);
        y0_q <= y0_q + (x0_q >>> rot_cnt_q);
        x1_q <= x1_q - (y1_q >>> rot_cnt_q);
        y1_q <= y1_q + (x1_q >>> rot_cnt_q);
        z_q  <= z_q - atan_of(rot_cnt_q);
      end else begin
        x0_q <= x0_q + (y0_q >>> rot_cnt_q);
        y0_q <= y0_q - (x0_q >>> rot_cnt_q);
        x1_q <= x1_q + (y1_q >>> rot_cnt_q);
        y1_q <= y1_q - (x1_q >>> rot_cnt_q);
        z_q  <= z_q + atan_of(rot_cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_cnt_q <= '0;
    end else if (cmd_i.rot_init) begin
      rot_cnt_q <= '0;
    end else if (cmd_i.rot_step) begin
      rot_cnt_q <= rot_cnt_q + 5'd1;
    end
  end

  // Gain stage: one multiplier, product registered, rounded and saturated result stored in the cycle after.
  logic [2:0]         mul_cnt_q;
  logic signed [32:0] mop;
  logic signed [63:0] prod_q, rnd;
  logic signed [19:0] shr;
  logic signed [15:0] sat;
  logic signed [15:0] bvx_q, bvy_q, bax_q, bay_q;

  always_comb begin
    case (mul_cnt_q)
      3'd0:    mop = x0_q;
      3'd1:    mop = y0_q;
      3'd2:    mop = x1_q;
      default: mop = y1_q;
    endcase
  end

  assign rnd = prod_q + 64'sd8796093022208;
  assign shr = rnd[63:44];
  assign sat = (shr > 20'sd32767) ? 16'sh7fff :
               (shr < -20'sd32768) ? 16'sh8000 : shr[15:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      prod_q <= 64'(mop) * 64'(CORDIC_GAIN);
      case (mul_cnt_q)
        3'd1:    bvx_q <= sat;
        3'd2:    bvy_q <= sat;
        3'd3:    bax_q <= sat;
        3'd4:    bay_q <= sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
    end else if (cmd_i.rot_init) begin
      mul_cnt_q <= '0;
    end else if (cmd_i.mul_step) begin
      mul_cnt_q <= mul_cnt_q + 3'd1;
    end
  end

  // Output register.
  logic out_valid_q;
  logic sel_ok, act_ok;
  assign sel_ok = (stat_q == ST_ACTIVE) || (stat_q == ST_GRACE);
  assign act_ok = stat_q == ST_ACTIVE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      result_o.status    <= stat_q;
      result_o.slot_used <= sel_ok ? sel_q : '0;
      if (stat_q == ST_STOP || (sel_ok && prog_one_q)) result_o.progress <= 17'h10000;
      else if (sel_ok) result_o.progress <= quo_q[16:0];
      else result_o.progress <= '0;
      result_o.body_vel_x        <= sel_ok ? bvx_q : '0;
      result_o.body_vel_y        <= sel_ok ? bvy_q : '0;
      result_o.body_acc_x        <= act_ok ? bax_q : '0;
      result_o.body_acc_y        <= act_ok ? bay_q : '0;
      result_o.spin_target       <= sel_ok ? rd_q.spin_rate : '0;
      result_o.spin_accel_target <= act_ok ? rd_q.spin_accel : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.sched     = time_q < start_q;
  assign sts_o.stop      = (n == '0) || (step_q == '0);
  assign sts_o.div_done  = div_cnt_q == 6'(DIV_STEPS - 1);
  assign sts_o.expired   = expired;
  assign sts_o.prog_skip = n <= COUNT_W'(1);
  assign sts_o.rot_done  = rot_cnt_q == 5'(CORDIC_STEPS - 1);
  assign sts_o.mul_done  = mul_cnt_q == 3'(MUL_STEPS - 1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// File: sv/trajectory_action_sampler.sv
// A load transfer writes the table and leaves the controller idle. A query passes two 64-step
// serial divides, 18 CORDIC iterations and the gain stage; scheduled or stopped queries skip
// these, expired ones end after the first divide, and with at most one action the second divide
// is skipped. One query is in flight at a time, and its result waits for a free output register.
// Reset (rst_ni, asynchronous, active low) clears configuration and control; the action
// table is not cleared and holds undefined contents until written.
`timescale 1ns / 1ps
module trajectory_action_sampler
  import tas_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tas_in_if.sink               in_if,
  tas_out_if.source            out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]          cfg_data_i
);

  // The controller sequences one query through the datapath: setup of the time
  // difference and slot length, the index divide, the table read and grace check,
  // the progress divide, the rotation and the gain stage, ending early when scheduled,
  // stopped or expired. Load transfers write the table directly while the controller is idle.
  cmd_t    cmd;
  sts_t    sts;
  action_t action;
  result_t result;

  assign action.field_vel_x = in_if.field_vel_x;
  assign action.field_vel_y = in_if.field_vel_y;
  assign action.spin_rate   = in_if.spin_rate;
  assign action.field_acc_x = in_if.field_acc_x;
  assign action.field_acc_y = in_if.field_acc_y;
  assign action.spin_accel  = in_if.spin_accel;

  tas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_mode_i  (in_if.mode),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tas_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .slot_i      (in_if.action_slot),
    .action_i    (action),
    .time_i      (in_if.query_time_us),
    .heading_i   (in_if.heading),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .result_o    (result)
  );

  // The output register parts the two sides, so the next item may transfer in
  // while a finished result still waits.
  assign out_if.status            = result.status;
  assign out_if.slot_used         = result.slot_used;
  assign out_if.progress          = result.progress;
  assign out_if.body_vel_x        = result.body_vel_x;
  assign out_if.body_vel_y        = result.body_vel_y;
  assign out_if.body_acc_x        = result.body_acc_x;
  assign out_if.body_acc_y        = result.body_acc_y;
  assign out_if.spin_target       = result.spin_target;
  assign out_if.spin_accel_target = result.spin_accel_target;

`ifndef ASSERT_OFF
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && in_if.mode |=> !in_if.ready)
    else $error("input ready right after a query transfer");

  a_grace_no_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status == ST_GRACE |->
      out_if.body_acc_x == 16'sd0 && out_if.body_acc_y == 16'sd0 &&
      out_if.spin_accel_target == 16'sd0)
    else $error("acceleration in grace hold");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status != ST_ACTIVE && out_if.status != ST_GRACE |->
      out_if.slot_used == '0)
    else $error("slot reported without a selected action");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.status <= ST_EXPIRED)
    else $error("status code out of range");
`endif

endmodule
